>>> src/multi_stack_push_pop_top_macros.svh
// Assertion macros for the multi-stack block.
// They expect clk and rst_n to be visible where they are used.
`ifndef MULTI_STACK_PUSH_POP_TOP_MACROS_SVH
`define MULTI_STACK_PUSH_POP_TOP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define MSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/msp_pkg.sv
// Shared types and codes for the multi-stack block.
// No dependencies; imported by msp_stack_mem, multi_stack_push_pop_top and the testbench.
package msp_pkg;

  // Request action codes
  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_DRAIN = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Result status codes
  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_POP_EMPTY   = 3'd1,
    STS_OVERFLOW    = 3'd2,
    STS_BAD_INDEX   = 3'd3,
    STS_DRAIN_EMPTY = 3'd4
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE  = 1'b0,
    S_DRAIN = 1'b1
  } state_t;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned CfgW    = 4;
  localparam logic [CfgW-1:0] CfgResetVal = 4'd8;

endpackage

>>> src/msp_stack_mem.sv
// Shared stack storage: one write port, one read port, registered read data.
// Depends on msp_pkg for the word width.
module msp_stack_mem import msp_pkg::*; #(
  parameter int unsigned AddrW = 8
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AddrW-1:0]        wr_addr,
  input  logic [ValueW-1:0]       wr_data,
  input  logic                    rd_en,
  input  logic [AddrW-1:0]        rd_addr,
  output logic [ValueW-1:0]       rd_data
);

  logic [ValueW-1:0] mem [2**AddrW];
  logic [ValueW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; hold data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/multi_stack_push_pop_top.sv
// Bank of LIFO stacks in one shared memory. Push, pop, bad-index and empty-drain requests
// give one result in the cycle after acceptance and may be accepted every cycle while the
// output is not stalled. A drain passes its entries top down through the memory read port
// into the output register, one per cycle while the output is not stalled; no request is
// accepted until its last value loads. Reset (rst_n low, synchronous) empties every stack,
// sets stacks_in_use to 8 and clears out_valid; the stack memory needs no clearing pass.
module multi_stack_push_pop_top import msp_pkg::*; #(
  parameter int unsigned NUM_STACKS  = 8,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CfgW-1:0]          cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic [IndexW-1:0]        in_stack_index,
  input  logic signed [ValueW-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ValueW-1:0] out_value,
  output logic [2:0]               out_status,
  output logic                     out_last
);

  `include "multi_stack_push_pop_top_macros.svh"

  localparam int unsigned SIW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned DW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned FW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = SIW + DW;
  localparam int unsigned CMPW  = 8;

  // Registers
  state_t                    state_r, state_nxt;
  logic [CfgW-1:0]           cfg_r;
  logic [FW-1:0]             fill_r [NUM_STACKS];
  logic [DW-1:0]             drain_ptr_r, drain_ptr_nxt;
  logic [SIW-1:0]            drain_idx_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [ValueW-1:0]         out_value_r;
  logic [2:0]                out_status_r;
  logic                      out_last_r;

  // Request decode
  logic [SIW+IndexW-1:0]     idx_ext;
  logic [SIW-1:0]            idx_sel;
  logic [FW-1:0]             cur_fill;
  logic                      bad_idx, full, empty;
  logic                      out_free, in_acc;
  logic                      drain_start;

  // Fill update and result load
  logic                      fill_we;
  logic [FW-1:0]             fill_wval;
  logic                      ld_en;
  logic [ValueW-1:0]         ld_value;
  status_t                   ld_status;
  logic                      ld_last;

  // Memory ports
  logic                      mem_wr_en, mem_rd_en;
  logic [AW-1:0]             mem_wr_addr, mem_rd_addr;
  logic [ValueW-1:0]         mem_rd_data;
  logic [DW-1:0]             top_ptr;

  msp_stack_mem #(.AddrW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (in_push_value),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Handshake; no request enters during a drain, so memory accesses never overlap
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;

  // Stack selection and status flags
  assign idx_ext  = {{SIW{1'b0}}, in_stack_index};
  assign idx_sel  = idx_ext[SIW-1:0];
  assign cur_fill = fill_r[idx_sel];
  assign bad_idx  = (CMPW'(in_stack_index) >= CMPW'(cfg_r)) ||
                    (CMPW'(in_stack_index) >= CMPW'(NUM_STACKS));
  assign full     = (cur_fill >= FW'(STACK_DEPTH));
  assign empty    = (cur_fill == '0);
  assign top_ptr  = DW'(cur_fill - 1'b1);

  // Outputs of the controller: memory, fill and result load
  always_comb begin
    mem_wr_en     = 1'b0;
    mem_wr_addr   = {idx_sel, DW'(cur_fill)};
    mem_rd_en     = 1'b0;
    mem_rd_addr   = {idx_sel, top_ptr};
    fill_we       = 1'b0;
    fill_wval     = cur_fill;
    drain_start   = 1'b0;
    drain_ptr_nxt = drain_ptr_r;
    ld_en         = 1'b0;
    ld_value      = '0;
    ld_status     = STS_OK;
    ld_last       = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (action_t'(in_action) != ACT_NONE)) begin
          ld_en = 1'b1;
          if (bad_idx) begin
            ld_status = STS_BAD_INDEX;
          end else begin
            case (action_t'(in_action))
              ACT_PUSH: begin
                if (full) begin
                  ld_status = STS_OVERFLOW;
                end else begin
                  mem_wr_en = 1'b1;
                  fill_we   = 1'b1;
                  fill_wval = cur_fill + 1'b1;
                end
              end
              ACT_POP: begin
                if (empty) begin
                  ld_status = STS_POP_EMPTY;
                end else begin
                  fill_we   = 1'b1;
                  fill_wval = cur_fill - 1'b1;
                end
              end
              ACT_DRAIN: begin
                if (empty) begin
                  ld_status = STS_DRAIN_EMPTY;
                end else begin
                  // Read the top entry; values come out while the stack is empty
                  ld_en         = 1'b0;
                  mem_rd_en     = 1'b1;
                  fill_we       = 1'b1;
                  fill_wval     = '0;
                  drain_start   = 1'b1;
                  drain_ptr_nxt = top_ptr;
                end
              end
              default: begin
                ld_en = 1'b0;
              end
            endcase
          end
        end
      end
      S_DRAIN: begin
        // When the output is free, emit the fetched entry and fetch the one below it, if any
        if (out_free) begin
          ld_en    = 1'b1;
          ld_value = mem_rd_data;
          ld_last  = (drain_ptr_r == '0);
          if (drain_ptr_r != '0) begin
            mem_rd_en     = 1'b1;
            mem_rd_addr   = {drain_idx_r, drain_ptr_r - 1'b1};
            drain_ptr_nxt = drain_ptr_r - 1'b1;
          end
        end
      end
      default: begin
        ld_en = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (drain_start) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (out_free && (drain_ptr_r == '0)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: drop on take, set on load
  assign out_valid_nxt = ld_en || (out_valid_r && out_stall);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CfgResetVal;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (fill_we) begin
        fill_r[idx_sel] <= fill_wval;
      end
    end
  end

  // Drain pointer and result payload
  always_ff @(posedge clk) begin
    drain_ptr_r <= drain_ptr_nxt;
    if (drain_start) begin
      drain_idx_r <= idx_sel;
    end
    if (ld_en) begin
      out_value_r  <= ld_value;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // Checks
  `MSP_ASSERT_NEXT(a_push_grows, (in_acc && mem_wr_en), (fill_r[$past(idx_sel)] == FW'($past(cur_fill) + 1'b1)), "push did not advance fill")
  `MSP_ASSERT_SAME(a_drain_empty, (state_r == S_DRAIN), (fill_r[drain_idx_r] == '0), "stack not empty while draining")
  `MSP_ASSERT_SAME(a_err_last, (out_valid_r && (out_status_r != STS_OK)), out_last_r, "error result without last")
  `MSP_ASSERT_SAME(a_fill_bound, 1'b1, (cur_fill <= FW'(STACK_DEPTH)), "fill beyond stack depth")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for multi_stack_push_pop_top: stack requests with random idling,
// checked result by result against a behavioral model of the stack bank.
// Depends on msp_pkg and the multi_stack_push_pop_top RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msp_pkg::*;

  localparam int unsigned NumStacks   = 8;
  localparam int unsigned StackDepth  = 32;
  localparam int unsigned DrainSettle = StackDepth + 8;
  localparam int unsigned CycleLimit  = 1_500_000;

  typedef struct packed {
    logic [ValueW-1:0] value;
    status_t           status;
    logic              last;
  } stack_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CfgW-1:0]          cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  action_t                  in_action = ACT_PUSH;
  logic [IndexW-1:0]        in_stack_index = '0;
  logic signed [ValueW-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ValueW-1:0] out_value;
  logic [2:0]               out_status;
  logic                     out_last;

  // Model state: stack contents, fill levels and the stacks_in_use register
  logic [ValueW-1:0] stack_words [NumStacks][StackDepth];
  int unsigned       stack_level [NumStacks];
  logic [CfgW-1:0]   stacks_in_use_reg;

  stack_result_t owed_results[$];
  int            fail_count = 0;
  int            cycle_count = 0;
  int            gap_pct = 0;
  int            stall_pct = 0;

  multi_stack_push_pop_top #(
    .NUM_STACKS  (NumStacks),
    .STACK_DEPTH (StackDepth)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_stack_index (in_stack_index),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle length: mostly none, some short, a few long
  function automatic int pick_idle(int pct);
    int r;
    if (pct == 0) return 0;
    r = $urandom_range(99);
    if (r < pct) return $urandom_range(1, 3);
    if (r < pct + 4) return $urandom_range(8, 20);
    return 0;
  endfunction

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    int stall_left;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_idle(stall_pct);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  function automatic void owe_result(logic [ValueW-1:0] value, status_t status, logic last);
    stack_result_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  // Apply one accepted request to the model and queue the results it causes
  function automatic void predict_stack_results(action_t act, logic [IndexW-1:0] idx,
                                                logic [ValueW-1:0] val);
    int unsigned enabled;
    int unsigned level;
    enabled = (stacks_in_use_reg > NumStacks) ? NumStacks : stacks_in_use_reg;
    if (act == ACT_NONE) return;
    if (idx >= enabled) begin
      owe_result('0, STS_BAD_INDEX, 1'b1);
      return;
    end
    level = stack_level[idx];
    case (act)
      ACT_PUSH: begin
        if (level >= StackDepth) begin
          owe_result('0, STS_OVERFLOW, 1'b1);
        end else begin
          stack_words[idx][level] = val;
          stack_level[idx] = level + 1;
          owe_result('0, STS_OK, 1'b1);
        end
      end
      ACT_POP: begin
        if (level == 0) begin
          owe_result('0, STS_POP_EMPTY, 1'b1);
        end else begin
          stack_level[idx] = level - 1;
          owe_result('0, STS_OK, 1'b1);
        end
      end
      default: begin
        // Drain: top to bottom, last flag on the bottom entry
        if (level == 0) begin
          owe_result('0, STS_DRAIN_EMPTY, 1'b1);
        end else begin
          while (level > 0) begin
            level--;
            owe_result(stack_words[idx][level], STS_OK, level == 0);
          end
          stack_level[idx] = 0;
        end
      end
    endcase
  endfunction

  // Check each accepted result against the oldest owed one
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: out_value %h out_status %0d out_last %0b",
               out_value, out_status, out_last);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_value !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, out_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Send one request; valid stays high into the next request when there is no gap
  task automatic send_request(action_t act, logic [IndexW-1:0] idx, logic [ValueW-1:0] val);
    int gap;
    gap = pick_idle(gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_stack_index <= idx;
    in_push_value  <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_stack_results(act, idx, val);
  endtask

  // Drop valid and wait until every owed result is in and the block settles
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DrainSettle) @(posedge clk);
  endtask

  task automatic write_stacks_in_use(logic [CfgW-1:0] count);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    stacks_in_use_reg = count;
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic action_t pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 5) return ACT_NONE;
    if (r < 55) return ACT_PUSH;
    if (r < 80) return ACT_POP;
    return ACT_DRAIN;
  endfunction

  // Extremes, every action, empty and bad-index cases, register extremes
  task automatic test_directed_cases();
    gap_pct   = 0;
    stall_pct = 0;
    send_request(ACT_PUSH, 3'd0, 32'h8000_0000);
    send_request(ACT_PUSH, 3'd0, 32'h7FFF_FFFF);
    send_request(ACT_PUSH, 3'd0, 32'h0000_0000);
    send_request(ACT_PUSH, 3'd7, 32'hFFFF_FFFF);
    send_request(ACT_PUSH, 3'd3, 32'h5555_AAAA);
    send_request(ACT_POP, 3'd0, 32'hFFFF_FFFF);
    send_request(ACT_DRAIN, 3'd0, '0);
    send_request(ACT_DRAIN, 3'd0, '0);
    send_request(ACT_POP, 3'd0, '0);
    send_request(ACT_NONE, 3'd5, 32'h1234_5678);
    send_request(ACT_NONE, 3'd0, '0);
    // Only stacks 0..2 enabled
    write_stacks_in_use(4'd3);
    send_request(ACT_PUSH, 3'd3, 32'hDEAD_BEEF);
    send_request(ACT_POP, 3'd7, '0);
    send_request(ACT_DRAIN, 3'd4, '0);
    send_request(ACT_PUSH, 3'd2, 32'hAAAA_5555);
    send_request(ACT_NONE, 3'd7, '0);
    // No stack enabled
    write_stacks_in_use(4'd0);
    send_request(ACT_PUSH, 3'd0, 32'h0000_0001);
    // Above the stack count saturates; contents survive the changes
    write_stacks_in_use(4'd15);
    send_request(ACT_PUSH, 3'd7, 32'h0F0F_F0F0);
    send_request(ACT_DRAIN, 3'd3, '0);
    send_request(ACT_DRAIN, 3'd7, '0);
    send_request(ACT_DRAIN, 3'd2, '0);
    write_stacks_in_use(4'd8);
  endtask

  // Fill one stack to the top, push past it, then drain all of it
  task automatic test_full_stack_overflow();
    logic [IndexW-1:0] idx;
    for (int pass = 0; pass < 2; pass++) begin
      gap_pct   = pass * 30;
      stall_pct = pass * 40;
      idx = IndexW'($urandom_range(NumStacks - 1));
      while (stack_level[idx] < StackDepth) send_request(ACT_PUSH, idx, pick_value());
      send_request(ACT_PUSH, idx, pick_value());
      send_request(ACT_PUSH, idx, pick_value());
      send_request(ACT_POP, idx, '0);
      send_request(ACT_PUSH, idx, pick_value());
      send_request(ACT_PUSH, idx, pick_value());
      send_request(ACT_DRAIN, idx, '0);
      send_request(ACT_POP, idx, '0);
    end
    wait_idle();
  endtask

  // Random requests in phases under different register settings and idling
  task automatic test_random_mix();
    logic [CfgW-1:0] phase_cfg [8];
    int unsigned enabled;
    int sent;
    action_t act;
    logic [IndexW-1:0] idx;
    phase_cfg = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd6, 4'd11, 4'd8};
    phase_cfg[7] = CfgW'($urandom_range(1, 15));
    for (int phase = 0; phase < 8; phase++) begin
      write_stacks_in_use(phase_cfg[phase]);
      enabled   = (phase_cfg[phase] > NumStacks) ? NumStacks : phase_cfg[phase];
      gap_pct   = (phase % 2) ? 0 : 20 + 10 * phase;
      stall_pct = (phase % 3 == 0) ? 0 : 15 + 5 * phase;
      sent = 0;
      while (sent < ((phase == 4) ? 8 : 14)) begin
        act = pick_action();
        if (enabled == 0 || $urandom_range(99) < 12) begin
          idx = IndexW'($urandom_range(NumStacks - 1));
        end else begin
          idx = IndexW'($urandom_range(enabled - 1));
        end
        send_request(act, idx, pick_value());
        if (act != ACT_NONE) sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    for (int s = 0; s < NumStacks; s++) stack_level[s] = 0;
    stacks_in_use_reg = CfgResetVal;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_full_stack_overflow();
    test_random_mix();
    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
